// File: sv/bfha_pkg.sv
`timescale 1ns / 1ps
package bfha_pkg;

  localparam int ADDR_BITS    = 24;
  localparam int MAX_EXTENTS  = 64;
  localparam int HEADER_BYTES = 16;
  localparam int ALIGN_BYTES  = 8;
  localparam int HEAP_RESET   = 10 * 1024 * 1024;
  localparam int STATUS_BITS  = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK     = 2'd0,
    ST_NO_FIT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef struct packed {
    logic ready;
    logic done;
  } ctrl_status_t;

endpackage

// File: sv/bfha_ram.sv
`timescale 1ns / 1ps
module bfha_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/bfha_ctrl.sv
`timescale 1ns / 1ps
module bfha_ctrl #(
  parameter int ADDR_BITS    = bfha_pkg::ADDR_BITS,
  parameter int MAX_EXTENTS  = bfha_pkg::MAX_EXTENTS,
  parameter int HEADER_BYTES = bfha_pkg::HEADER_BYTES,
  parameter int ALIGN_BYTES  = bfha_pkg::ALIGN_BYTES
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [ADDR_BITS-1:0]         heap_i,
  input  logic                         cfg_we_i,
  input  logic                         req_i,
  input  logic                         op_i,
  input  logic [ADDR_BITS-1:0]         size_i,
  input  logic [ADDR_BITS-1:0]         addr_i,
  input  logic                         out_ready_i,
  output bfha_pkg::ctrl_status_t       status_o,
  output logic [ADDR_BITS-1:0]         res_addr_o,
  output bfha_pkg::status_e            res_status_o
);

  localparam int AW = ADDR_BITS;
  localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int NW = AW + 2;
  localparam logic [AW-1:0] HDR      = AW'(HEADER_BYTES);
  localparam logic [AW-1:0] HDR2     = AW'(2 * HEADER_BYTES);
  localparam logic [NW-1:0] NEED_ADD = NW'(HEADER_BYTES + ALIGN_BYTES - 1);
  localparam logic [NW-1:0] NEED_MSK = ~NW'(ALIGN_BYTES - 1);
  localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_EXTENTS);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_A_SUB, S_F_DEC, S_F_ACT, S_SH_RD, S_SH_WR, S_FIN_WR, S_OUT
  } state_e;

  state_e            state_q;
  logic              init_q;
  logic [CW-1:0]     count_q, cnt_next_q, issue_q, chk_q, pos_q, sh_q;
  logic              dv_q, found_q, op_q, has_prev_q, has_next_q, jn_q, jp_q, sh_up_q;
  logic [IW-1:0]     best_idx_q, fin_idx_q;
  logic [AW-1:0]     best_base_q, best_size_q, hdr_q, fsize_q, nsize_q;
  logic [AW-1:0]     prev_base_q, prev_size_q, next_base_q, next_size_q;
  logic [AW-1:0]     fin_base_q, fin_size_q, res_addr_q;
  logic [NW-1:0]     need_q;
  bfha_pkg::status_e res_status_q;

  logic              ram_we;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  logic [2*AW-1:0]   ram_wdata, ram_rdata;
  logic [AW-1:0]     rd_base, rd_size, init_size, end_addr, prev_end;
  logic              last_chk;

  assign rd_base   = ram_rdata[AW-1:0];
  assign rd_size   = ram_rdata[2*AW-1:AW];
  assign init_size = (heap_i >= HDR) ? heap_i - HDR : '0;
  assign last_chk  = (chk_q + CNT_ONE) == count_q;
  assign end_addr  = hdr_q + HDR + fsize_q;
  assign prev_end  = prev_base_q + HDR + prev_size_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fin_idx_q;
    ram_wdata = {fin_size_q, fin_base_q};
    ram_raddr = issue_q[IW-1:0];
    unique case (state_q)
      S_IDLE: begin
        ram_we    = init_q;
        ram_waddr = '0;
        ram_wdata = {init_size, {AW{1'b0}}};
      end
      S_SH_RD:  ram_raddr = sh_up_q ? IW'(sh_q - CNT_ONE) : IW'(sh_q + CNT_ONE);
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = sh_q[IW-1:0];
        ram_wdata = ram_rdata;
      end
      S_FIN_WR: ram_we = 1'b1;
      default: ;
    endcase
  end

  bfha_ram #(.WIDTH(2 * AW), .DEPTH(MAX_EXTENTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      init_q       <= 1'b1;
      count_q      <= CNT_ONE;
      dv_q         <= 1'b0;
      res_addr_q   <= '0;
      res_status_q <= bfha_pkg::ST_OK;
    end else begin
      if (cfg_we_i) init_q <= 1'b1;
      unique case (state_q)
        S_IDLE: begin
          if (init_q) begin
            init_q  <= cfg_we_i;
            count_q <= CNT_ONE;
          end else if (req_i) begin
            op_q       <= op_i;
            issue_q    <= '0;
            dv_q       <= 1'b0;
            found_q    <= 1'b0;
            has_prev_q <= 1'b0;
            need_q     <= ({2'b00, size_i} + NEED_ADD) & NEED_MSK;
            hdr_q      <= addr_i - HDR;
            fsize_q    <= size_i;
            if (op_i == bfha_pkg::OP_FREE && addr_i == '0) begin
              res_addr_q   <= '0;
              res_status_q <= bfha_pkg::ST_OK;
              state_q      <= S_OUT;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          dv_q  <= issue_q != count_q;
          chk_q <= issue_q;
          if (issue_q != count_q) issue_q <= issue_q + CNT_ONE;
          if (dv_q) begin
            if (op_q == bfha_pkg::OP_ALLOC) begin
              if ({2'b00, rd_size} >= need_q && (!found_q || rd_size < best_size_q)) begin
                found_q     <= 1'b1;
                best_idx_q  <= chk_q[IW-1:0];
                best_base_q <= rd_base;
                best_size_q <= rd_size;
              end
              if (last_chk) state_q <= S_A_SUB;
            end else if (rd_base < hdr_q) begin
              has_prev_q  <= 1'b1;
              prev_base_q <= rd_base;
              prev_size_q <= rd_size;
              if (last_chk) begin
                pos_q      <= count_q;
                has_next_q <= 1'b0;
                state_q    <= S_F_DEC;
              end
            end else begin
              pos_q       <= chk_q;
              has_next_q  <= 1'b1;
              next_base_q <= rd_base;
              next_size_q <= rd_size;
              state_q     <= S_F_DEC;
            end
          end
        end
        S_A_SUB: begin
          if (!found_q) begin
            res_addr_q   <= '0;
            res_status_q <= bfha_pkg::ST_NO_FIT;
            state_q      <= S_OUT;
          end else begin
            fin_idx_q  <= best_idx_q;
            fin_base_q <= best_base_q;
            fin_size_q <= best_size_q - need_q[AW-1:0];
            cnt_next_q <= count_q;
            state_q    <= S_FIN_WR;
          end
        end
        S_F_DEC: begin
          jn_q    <= has_next_q && end_addr == next_base_q;
          jp_q    <= has_prev_q && prev_end == hdr_q;
          nsize_q <= (has_next_q && end_addr == next_base_q) ?
                     fsize_q + HDR + next_size_q : fsize_q;
          state_q <= S_F_ACT;
        end
        S_F_ACT: begin
          cnt_next_q <= count_q;
          if (jp_q) begin
            fin_idx_q  <= IW'(pos_q - CNT_ONE);
            fin_base_q <= prev_base_q;
            fin_size_q <= prev_size_q + HDR + nsize_q;
            sh_q       <= pos_q;
            sh_up_q    <= 1'b0;
            if (jn_q) begin
              cnt_next_q <= count_q - CNT_ONE;
              state_q    <= ((pos_q + CNT_ONE) < count_q) ? S_SH_RD : S_FIN_WR;
            end else begin
              state_q <= S_FIN_WR;
            end
          end else begin
            fin_idx_q  <= pos_q[IW-1:0];
            fin_base_q <= hdr_q;
            fin_size_q <= nsize_q;
            sh_q       <= count_q;
            sh_up_q    <= 1'b1;
            if (jn_q) begin
              state_q <= S_FIN_WR;
            end else if (count_q == CNT_MAX) begin
              res_addr_q   <= '0;
              res_status_q <= bfha_pkg::ST_FULL;
              state_q      <= S_OUT;
            end else begin
              cnt_next_q <= count_q + CNT_ONE;
              state_q    <= (count_q > pos_q) ? S_SH_RD : S_FIN_WR;
            end
          end
        end
        S_SH_RD: state_q <= S_SH_WR;
        S_SH_WR: begin
          if (sh_up_q) begin
            sh_q    <= sh_q - CNT_ONE;
            state_q <= ((sh_q - CNT_ONE) > pos_q) ? S_SH_RD : S_FIN_WR;
          end else begin
            sh_q    <= sh_q + CNT_ONE;
            state_q <= ((sh_q + CW'(2)) < count_q) ? S_SH_RD : S_FIN_WR;
          end
        end
        S_FIN_WR: begin
          count_q      <= cnt_next_q;
          res_addr_q   <= (op_q == bfha_pkg::OP_ALLOC) ? fin_base_q + fin_size_q + HDR2 : '0;
          res_status_q <= bfha_pkg::ST_OK;
          state_q      <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign status_o.ready = (state_q == S_IDLE) && !init_q;
  assign status_o.done  = (state_q == S_OUT) && out_ready_i;
  assign res_addr_o     = res_addr_q;
  assign res_status_o   = res_status_q;

endmodule

// File: sv/best_fit_heap_allocator_top.sv
`timescale 1ns / 1ps
// Best-fit heap allocator with an address-sorted free-extent table.
// Requests enter on s_axis: tuser selects allocate (0) or free (1), tdata
// carries the size and, for a free, the payload address. One result per
// request leaves on m_axis: the payload address and a status code
// (ok, no fit, table full).
// An allocate scans all N live extents. A free scans up to its insertion
// point, then may shift the upper part of the table by one place.
// The table memory has one write port and one registered read port.
// One request is in work at a time; s_axis_tready is low meanwhile.
// Results sit in an output register, so a new request is taken while the
// last result still waits; a stalled receiver holds the next finished
// request in the sequencer until the register drains.
// Reset, and any cfg write of heap_bytes, rebuilds the table as one extent
// covering the heap, with s_axis_tready low while it does so.
module best_fit_heap_allocator_top #(
  parameter int ADDR_BITS    = bfha_pkg::ADDR_BITS,
  parameter int MAX_EXTENTS  = bfha_pkg::MAX_EXTENTS,
  parameter int HEADER_BYTES = bfha_pkg::HEADER_BYTES,
  parameter int ALIGN_BYTES  = bfha_pkg::ALIGN_BYTES,
  localparam int IN_W  = ((2 * ADDR_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((ADDR_BITS + bfha_pkg::STATUS_BITS + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [ADDR_BITS-1:0] cfg_wdata_i,     // heap_bytes
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_W-1:0]      s_axis_tdata,    // request_size, block_address
  input  logic                 s_axis_tuser,    // op
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_W-1:0]     m_axis_tdata     // result_address, status
);

  localparam int AW = ADDR_BITS;

  logic [AW-1:0]          heap_q;
  logic                   m_valid_q;
  logic [AW-1:0]          m_addr_q;
  bfha_pkg::status_e      m_status_q;
  bfha_pkg::ctrl_status_t ctrl_st;
  logic [AW-1:0]          res_addr;
  bfha_pkg::status_e      res_status;
  logic                   out_ready;

  assign out_ready     = !m_valid_q || m_axis_tready;
  assign s_axis_tready = ctrl_st.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_q    <= AW'(bfha_pkg::HEAP_RESET);
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) heap_q <= cfg_wdata_i;
      if (ctrl_st.done) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_st.done) begin
      m_addr_q   <= res_addr;
      m_status_q <= res_status;
    end
  end

  bfha_ctrl #(
    .ADDR_BITS    (ADDR_BITS),
    .MAX_EXTENTS  (MAX_EXTENTS),
    .HEADER_BYTES (HEADER_BYTES),
    .ALIGN_BYTES  (ALIGN_BYTES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .heap_i       (heap_q),
    .cfg_we_i     (cfg_we_i),
    .req_i        (s_axis_tvalid && s_axis_tready),
    .op_i         (s_axis_tuser),
    .size_i       (s_axis_tdata[AW-1:0]),
    .addr_i       (s_axis_tdata[2*AW-1:AW]),
    .out_ready_i  (out_ready),
    .status_o     (ctrl_st),
    .res_addr_o   (res_addr),
    .res_status_o (res_status)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_W'({m_status_q, m_addr_q});

endmodule

// File: sv/bfha_checker.sv
`timescale 1ns / 1ps
module bfha_checker #(
  parameter int ADDR_BITS = bfha_pkg::ADDR_BITS,
  parameter int OUT_W     = 32
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  localparam int SB = bfha_pkg::STATUS_BITS;

  logic [SB-1:0] st;
  assign st = m_axis_tdata[ADDR_BITS+SB-1:ADDR_BITS];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (st == bfha_pkg::ST_OK || st == bfha_pkg::ST_NO_FIT ||
                       st == bfha_pkg::ST_FULL))
    else $error("bad status code");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st != bfha_pkg::ST_OK |-> m_axis_tdata[ADDR_BITS-1:0] == '0)
    else $error("failed request returns nonzero address");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

endmodule

bind best_fit_heap_allocator_top bfha_checker #(
  .ADDR_BITS (ADDR_BITS),
  .OUT_W     (OUT_W)
) u_bfha_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
